// ----- src/ivs_pkg.sv -----
`default_nettype none

package ivs_pkg;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PANEL = 2'd1,
        FUNC_VALVE = 2'd2,
        FUNC_SPARE = 2'd3
    } t_func;

    // System mode
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_IGNITION = 2'd1,
        MODE_TIMEOUT  = 2'd2,
        MODE_LINK_ERR = 2'd3
    } t_mode;

    // Ignition sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_IGNITER = 2'd2,
        PH_VALVE   = 2'd3
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LINK_TIMEOUT = 3'd0,
        CFG_IGNITE_WAIT  = 3'd1,
        CFG_IGNITER_ON   = 3'd2,
        CFG_BURN_TIMEOUT = 3'd3,
        CFG_CLOSED_ANGLE = 3'd4,
        CFG_OPEN_ANGLE   = 3'd5
    } t_cfg_idx;

    // Button byte bit positions
    localparam int BTN_DUMP  = 0;
    localparam int BTN_FIRE  = 1;
    localparam int BTN_FILL  = 2;
    localparam int BTN_SEP   = 3;
    localparam int BTN_CLOSE = 4;
    localparam int BTN_TEST  = 5;
    localparam int BTN_OPEN  = 6;

    // Solenoid level bit positions
    localparam int SOL_DUMP = 0;
    localparam int SOL_FILL = 1;
    localparam int SOL_SEP  = 2;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    // Configuration reset values
    localparam logic [15:0]        LINK_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0]        IGNITE_WAIT_RST  = 16'd20000;
    localparam logic [15:0]        IGNITER_ON_RST   = 16'd2000;
    localparam logic [15:0]        BURN_TIMEOUT_RST = 16'd10000;
    localparam logic signed [11:0] CLOSED_ANGLE_RST = -12'sd90;
    localparam logic signed [11:0] OPEN_ANGLE_RST   = 12'sd1350;

    typedef struct packed {
        logic [15:0]        link_timeout_ms;
        logic [15:0]        ignite_wait_ms;
        logic [15:0]        igniter_on_ms;
        logic [15:0]        burn_timeout_ms;
        logic signed [11:0] valve_closed_angle;
        logic signed [11:0] valve_open_angle;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] button_bits;
        logic       has_payload;
    } t_item;

    typedef struct packed {
        logic               dump_out;
        logic               fill_out;
        logic               separate_out;
        logic               oxygen_out;
        logic               igniter_out;
        logic signed [11:0] angle_cmd;
        logic [1:0]         mode;
    } t_result;

    // Saturating increment of a link age or phase timer
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == AGE_MAX) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// ----- src/ivs_if.sv -----
`default_nettype none

// Input item channel
interface ivs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] button_bits;
    logic       has_payload;

    modport source(output valid, output func, output button_bits, output has_payload,
                   input ready);
    modport sink(input valid, input func, input button_bits, input has_payload,
                 output ready);
endinterface

// Result channel
interface ivs_result_if;
    logic               valid;
    logic               ready;
    logic               dump_out;
    logic               fill_out;
    logic               separate_out;
    logic               oxygen_out;
    logic               igniter_out;
    logic signed [11:0] angle_cmd;
    logic [1:0]         mode;

    modport source(output valid, output dump_out, output fill_out, output separate_out,
                   output oxygen_out, output igniter_out, output angle_cmd, output mode,
                   input ready);
    modport sink(input valid, input dump_out, input fill_out, input separate_out,
                 input oxygen_out, input igniter_out, input angle_cmd, input mode,
                 output ready);
endinterface

// Configuration write channel
interface ivs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ivs_cfg.sv -----
`default_nettype none

module ivs_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    ivs_cfg_if.sink           i_cfg,
    output ivs_pkg::t_cfg     o_cfg
);

    ivs_pkg::t_cfg r_cfg;

    // Always take writes
    assign i_cfg.ready = 1'b1;

    // Store register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_ms    <= ivs_pkg::LINK_TIMEOUT_RST;
            r_cfg.ignite_wait_ms     <= ivs_pkg::IGNITE_WAIT_RST;
            r_cfg.igniter_on_ms      <= ivs_pkg::IGNITER_ON_RST;
            r_cfg.burn_timeout_ms    <= ivs_pkg::BURN_TIMEOUT_RST;
            r_cfg.valve_closed_angle <= ivs_pkg::CLOSED_ANGLE_RST;
            r_cfg.valve_open_angle   <= ivs_pkg::OPEN_ANGLE_RST;
        end else if (i_cfg.valid) begin
            case (ivs_pkg::t_cfg_idx'(i_cfg.index))
                ivs_pkg::CFG_LINK_TIMEOUT: r_cfg.link_timeout_ms <= i_cfg.data;
                ivs_pkg::CFG_IGNITE_WAIT:  r_cfg.ignite_wait_ms  <= i_cfg.data;
                ivs_pkg::CFG_IGNITER_ON:   r_cfg.igniter_on_ms   <= i_cfg.data;
                ivs_pkg::CFG_BURN_TIMEOUT: r_cfg.burn_timeout_ms <= i_cfg.data;
                ivs_pkg::CFG_CLOSED_ANGLE: r_cfg.valve_closed_angle <= i_cfg.data[11:0];
                ivs_pkg::CFG_OPEN_ANGLE:   r_cfg.valve_open_angle   <= i_cfg.data[11:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- src/ivs_core.sv -----
`default_nettype none

module ivs_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire ivs_pkg::t_item i_item,
    input  wire ivs_pkg::t_cfg  i_cfg,
    output ivs_pkg::t_result    o_result
);

    typedef struct packed {
        ivs_pkg::t_mode     mode;
        logic               timed_out;
        logic               auto_oxy;
        logic               run_req;
        logic               man_oxy;
        logic               prev_test;
        logic [7:0]         button;
        logic [15:0]        panel_age;
        logic [15:0]        valve_age;
        ivs_pkg::t_phase    phase;
        logic [15:0]        timer;
        logic signed [11:0] angle;
        logic [2:0]         sol;
        logic               oxy_lvl;
        logic               ign_lvl;
    } t_state;

    t_state r_st;
    t_state n_st;

    // Work out the state after one item: watchdog, button rules, sequencer
    always_comb begin
        logic        alive;
        logic        running;
        logic        oxy_before;
        logic        fire;
        logic        test;
        logic [15:0] dur;
        logic [15:0] t_inc;

        n_st       = r_st;
        alive      = 1'b0;
        running    = 1'b0;
        oxy_before = 1'b0;
        fire       = r_st.button[ivs_pkg::BTN_FIRE];
        test       = r_st.button[ivs_pkg::BTN_TEST];
        dur        = i_cfg.burn_timeout_ms;
        t_inc      = ivs_pkg::sat_inc(r_st.timer);

        case (ivs_pkg::t_func'(i_item.func))
            ivs_pkg::FUNC_TICK: begin
                n_st.panel_age = ivs_pkg::sat_inc(r_st.panel_age);
                n_st.valve_age = ivs_pkg::sat_inc(r_st.valve_age);

                // Link watchdog
                alive = (n_st.panel_age < i_cfg.link_timeout_ms) &&
                        (n_st.valve_age < i_cfg.link_timeout_ms);
                if (alive) begin
                    if (n_st.mode == ivs_pkg::MODE_LINK_ERR) begin
                        n_st.mode = r_st.timed_out ? ivs_pkg::MODE_TIMEOUT
                                                   : ivs_pkg::MODE_IDLE;
                    end
                end else begin
                    n_st.mode     = ivs_pkg::MODE_LINK_ERR;
                    n_st.auto_oxy = 1'b0;
                    n_st.run_req  = 1'b0;
                    n_st.oxy_lvl  = 1'b0;
                    n_st.sol[ivs_pkg::SOL_FILL] = 1'b0;
                    n_st.ign_lvl  = 1'b0;
                end

                // Button and valve rules
                if (n_st.mode == ivs_pkg::MODE_LINK_ERR) begin
                    n_st.auto_oxy  = 1'b0;
                    n_st.run_req   = 1'b0;
                    n_st.man_oxy   = 1'b0;
                    n_st.prev_test = test;
                    n_st.sol[ivs_pkg::SOL_FILL] = 1'b0;
                    n_st.oxy_lvl   = 1'b0;
                    n_st.ign_lvl   = 1'b0;
                end else begin
                    oxy_before = n_st.auto_oxy;
                    running = (n_st.mode == ivs_pkg::MODE_IGNITION) ||
                              (fire && n_st.mode == ivs_pkg::MODE_IDLE);
                    if (!running) begin
                        n_st.sol[ivs_pkg::SOL_DUMP] = r_st.button[ivs_pkg::BTN_DUMP];
                        n_st.sol[ivs_pkg::SOL_FILL] = r_st.button[ivs_pkg::BTN_FILL];
                        n_st.sol[ivs_pkg::SOL_SEP]  = r_st.button[ivs_pkg::BTN_SEP];
                    end
                    if (fire) begin
                        if (n_st.mode == ivs_pkg::MODE_IDLE) begin
                            n_st.auto_oxy = 1'b1;
                            n_st.mode     = ivs_pkg::MODE_IGNITION;
                            n_st.run_req  = 1'b1;
                        end else if (n_st.mode == ivs_pkg::MODE_TIMEOUT) begin
                            n_st.angle = i_cfg.valve_open_angle;
                        end
                    end
                    if (r_st.button[ivs_pkg::BTN_CLOSE] && !running) begin
                        n_st.angle = i_cfg.valve_closed_angle;
                    end
                    if (r_st.button[ivs_pkg::BTN_OPEN]) begin
                        n_st.angle = i_cfg.valve_open_angle;
                    end
                    if (running) begin
                        n_st.man_oxy = 1'b0;
                    end else if (test && !r_st.prev_test) begin
                        n_st.man_oxy = 1'b1;
                    end else if (!test && r_st.prev_test) begin
                        n_st.man_oxy = 1'b0;
                    end
                    n_st.prev_test = test;
                    n_st.oxy_lvl   = oxy_before || (!running && n_st.man_oxy);
                end

                // Ignition sequencer
                if (r_st.phase == ivs_pkg::PH_IDLE) begin
                    if (n_st.run_req) begin
                        n_st.phase = ivs_pkg::PH_WAIT;
                        n_st.timer = 16'd0;
                    end
                end else begin
                    if (r_st.phase == ivs_pkg::PH_WAIT) begin
                        dur = i_cfg.ignite_wait_ms;
                    end else if (r_st.phase == ivs_pkg::PH_IGNITER) begin
                        dur = i_cfg.igniter_on_ms;
                    end
                    if (t_inc < dur) begin
                        n_st.timer = t_inc;
                    end else if (n_st.mode == ivs_pkg::MODE_LINK_ERR || !n_st.run_req) begin
                        // Abort at phase end
                        n_st.ign_lvl = 1'b0;
                        n_st.phase   = ivs_pkg::PH_IDLE;
                        n_st.timer   = 16'd0;
                    end else begin
                        n_st.timer = 16'd0;
                        if (r_st.phase == ivs_pkg::PH_WAIT) begin
                            n_st.ign_lvl = 1'b1;
                            n_st.phase   = ivs_pkg::PH_IGNITER;
                        end else if (r_st.phase == ivs_pkg::PH_IGNITER) begin
                            n_st.ign_lvl  = 1'b0;
                            n_st.angle    = i_cfg.valve_open_angle;
                            n_st.auto_oxy = 1'b0;
                            n_st.phase    = ivs_pkg::PH_VALVE;
                        end else begin
                            n_st.mode      = ivs_pkg::MODE_TIMEOUT;
                            n_st.timed_out = 1'b1;
                            n_st.run_req   = 1'b0;
                            n_st.ign_lvl   = 1'b0;
                            n_st.phase     = ivs_pkg::PH_IDLE;
                        end
                    end
                end
            end
            ivs_pkg::FUNC_PANEL: begin
                n_st.panel_age = 16'd0;
                if (i_item.has_payload) begin
                    n_st.button = i_item.button_bits;
                end
            end
            ivs_pkg::FUNC_VALVE: begin
                n_st.valve_age = 16'd0;
            end
            default: begin
            end
        endcase
    end

    // Hold state between items, advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode      <= ivs_pkg::MODE_IDLE;
            r_st.timed_out <= 1'b0;
            r_st.auto_oxy  <= 1'b0;
            r_st.run_req   <= 1'b0;
            r_st.man_oxy   <= 1'b0;
            r_st.prev_test <= 1'b0;
            r_st.button    <= 8'd0;
            r_st.panel_age <= 16'd0;
            r_st.valve_age <= 16'd0;
            r_st.phase     <= ivs_pkg::PH_IDLE;
            r_st.timer     <= 16'd0;
            r_st.angle     <= ivs_pkg::CLOSED_ANGLE_RST;
            r_st.sol       <= 3'd0;
            r_st.oxy_lvl   <= 1'b0;
            r_st.ign_lvl   <= 1'b0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    // Result of the item being stepped
    always_comb begin
        o_result.dump_out     = n_st.sol[ivs_pkg::SOL_DUMP];
        o_result.fill_out     = n_st.sol[ivs_pkg::SOL_FILL];
        o_result.separate_out = n_st.sol[ivs_pkg::SOL_SEP];
        o_result.oxygen_out   = n_st.oxy_lvl;
        o_result.igniter_out  = n_st.ign_lvl;
        o_result.angle_cmd    = n_st.angle;
        o_result.mode         = n_st.mode;
    end

endmodule

`default_nettype wire

// ----- src/ignition_valve_sequencer_top.sv -----
// Channel   Dir  Handshake      Payload
// i_item    in   valid/ready    func, button_bits, has_payload
// o_res     out  valid/ready    dump/fill/separate/oxygen/igniter_out, angle_cmd, mode
// i_cfg     in   valid/ready    index (0..5), data (16 bits, angles use [11:0])
//
// One item per cycle sustained while results are taken; a result passes through the
// input register, then the state update into the result register, before it is valid.
// Reset is synchronous on i_rst_n low and restores the configuration, core state and valid flags.
// A stalled result holds the result register; the input register still takes one
// more item, then i_item.ready drops until the result is taken.
// Configuration writes complete in the cycle they are offered.
`default_nettype none

module ignition_valve_sequencer_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ivs_item_if.sink      i_item,
    ivs_result_if.source  o_res,
    ivs_cfg_if.sink       i_cfg
);

    ivs_pkg::t_cfg    w_cfg;
    ivs_pkg::t_result w_result;
    ivs_pkg::t_item   r_item;
    ivs_pkg::t_result r_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             w_adv;
    logic             w_step;

    ivs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ivs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Move a transaction forward when the result register is free or drains
    assign w_adv        = !r_out_valid || o_res.ready;
    assign w_step       = r_in_valid && w_adv;
    assign i_item.ready = !r_in_valid || w_adv;

    // Valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture input item and result payloads
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.func        <= i_item.func;
            r_item.button_bits <= i_item.button_bits;
            r_item.has_payload <= i_item.has_payload;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    // Drive the result channel
    assign o_res.valid        = r_out_valid;
    assign o_res.dump_out     = r_out.dump_out;
    assign o_res.fill_out     = r_out.fill_out;
    assign o_res.separate_out = r_out.separate_out;
    assign o_res.oxygen_out   = r_out.oxygen_out;
    assign o_res.igniter_out  = r_out.igniter_out;
    assign o_res.angle_cmd    = r_out.angle_cmd;
    assign o_res.mode         = r_out.mode;

endmodule

`default_nettype wire
